### rtl/clbws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clbws_pkg
// Shared types, constants and unit tables of the character LCD bus sequencer.
// ----------------------------------------------------------------------------
package clbws_pkg;

    localparam logic [1:0] CMD_INIT   = 2'd0;
    localparam logic [1:0] CMD_WRCMD  = 2'd1;
    localparam logic [1:0] CMD_WRDATA = 2'd2;
    localparam logic [1:0] CMD_CURSOR = 2'd3;

    localparam logic [1:0] REG_BUS_MODE    = 2'd0;
    localparam logic [1:0] REG_PULSE_MS    = 2'd1;
    localparam logic [1:0] REG_POWER_UP_MS = 2'd2;

    localparam logic [7:0] RST_PULSE_MS    = 8'd2;
    localparam logic [7:0] RST_POWER_UP_MS = 8'd40;

    localparam logic [7:0] FUNC_SET_8 = 8'b0011_1000;
    localparam logic [7:0] DISPLAY_ON = 8'b0000_1100;
    localparam logic [7:0] CLEAR_DISP = 8'h01;
    localparam logic [7:0] ROW1_BASE  = 8'h40;
    localparam logic [7:0] DDRAM_FLAG = 8'h80;
    localparam logic [3:0] FS_NIB_A   = 4'b0010;
    localparam logic [3:0] FS_NIB_B   = 4'b1000;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       bus_mode;
        logic [7:0] pulse_ms;
        logic [7:0] power_up_ms;
    } t_cfg;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] value;
    } t_desc;

    function automatic logic [7:0] nib_hi(input logic [3:0] nib);
        return {nib, 4'b0000};
    endfunction

    // Index of the final unit of a request
    function automatic logic [2:0] last_unit(input logic is_init, input logic mode);
        logic [2:0] res;
        if (is_init) begin
            res = mode ? 3'd6 : 3'd2;
        end else begin
            res = mode ? 3'd1 : 3'd0;
        end
        return res;
    endfunction

    // Bus value of unit k of a request
    function automatic logic [7:0] unit_bus(input t_desc d, input logic mode,
                                            input logic [2:0] k);
        logic [7:0] res;
        res = 8'h00;
        if (d.is_init && mode) begin
            case (k)
                3'd0:    res = nib_hi(FS_NIB_A);
                3'd1:    res = nib_hi(FS_NIB_A);
                3'd2:    res = nib_hi(FS_NIB_B);
                3'd3:    res = nib_hi(DISPLAY_ON[7:4]);
                3'd4:    res = nib_hi(DISPLAY_ON[3:0]);
                3'd5:    res = nib_hi(CLEAR_DISP[7:4]);
                3'd6:    res = nib_hi(CLEAR_DISP[3:0]);
                default: res = 8'h00;
            endcase
        end else if (d.is_init) begin
            case (k)
                3'd0:    res = FUNC_SET_8;
                3'd1:    res = DISPLAY_ON;
                3'd2:    res = CLEAR_DISP;
                default: res = 8'h00;
            endcase
        end else if (mode) begin
            res = (k == 3'd0) ? nib_hi(d.value[7:4]) : nib_hi(d.value[3:0]);
        end else begin
            res = d.value;
        end
        return res;
    endfunction

endpackage

### rtl/clbws_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clbws_regs
// APB configuration registers: bus mode, enable pulse width, power-up wait.
// ----------------------------------------------------------------------------
module clbws_regs
    import clbws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic       r_bus_mode;
    logic [7:0] r_pulse_ms;
    logic [7:0] r_power_up_ms;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_mode    <= 1'b0;
            r_pulse_ms    <= RST_PULSE_MS;
            r_power_up_ms <= RST_POWER_UP_MS;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_BUS_MODE:    r_bus_mode    <= pwdata[0];
                REG_PULSE_MS:    r_pulse_ms    <= pwdata[7:0];
                REG_POWER_UP_MS: r_power_up_ms <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BUS_MODE:    prdata = {31'd0, r_bus_mode};
            REG_PULSE_MS:    prdata = {24'd0, r_pulse_ms};
            REG_POWER_UP_MS: prdata = {24'd0, r_power_up_ms};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{bus_mode: r_bus_mode, pulse_ms: r_pulse_ms,
                     power_up_ms: r_power_up_ms};

endmodule

### rtl/clbws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clbws_front
// Request intake: accepts a transaction and classifies it into a descriptor.
// ----------------------------------------------------------------------------
module clbws_front
    import clbws_pkg::*;
(
    input  logic       i_start,
    input  logic       i_full,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_byte_value,
    input  logic [5:0] i_column,
    input  logic       i_row,
    output logic       o_push,
    output t_desc      o_desc
);

    logic [7:0] addr;

    assign o_push = i_start & ~i_full;
    assign addr   = (i_row ? ROW1_BASE : 8'h00) + {2'b00, i_column};

    always_comb begin
        o_desc = '{is_init: 1'b0, rs: 1'b0, value: i_byte_value};
        case (i_cmd)
            CMD_INIT:   o_desc.is_init = 1'b1;
            CMD_WRCMD:  o_desc.rs = 1'b0;
            CMD_WRDATA: o_desc.rs = 1'b1;
            CMD_CURSOR: o_desc.value = addr | DDRAM_FLAG;
            default:    o_desc.rs = 1'b0;
        endcase
    end

endmodule

### rtl/clbws_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clbws_queue
// Two-entry descriptor queue between request intake and the pin sequencer.
// ----------------------------------------------------------------------------
module clbws_queue
    import clbws_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_desc o_head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW:0] FULL_CNT = (PW+1)'(QUEUE_DEPTH);

    t_desc         r_entry [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_entry[r_rd_ptr];
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !do_pop) |=> (r_count == $past(r_count) + (PW+1)'(1)))
        else $error("queue count did not follow push");
`endif

endmodule

### rtl/clbws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clbws_back
// Pin sequencer: expands descriptors into setup, strobe and release states, after a power-up wait state for init.
// ----------------------------------------------------------------------------
module clbws_back
    import clbws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  t_desc      i_head,
    output logic       o_pop,
    output logic       o_strobe,
    output logic       o_reg_select,
    output logic       o_read_write,
    output logic       o_enable,
    output logic [7:0] o_bus,
    output logic [7:0] o_hold_ms,
    output logic       o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_UNIT
    } t_state;

    localparam logic [1:0] PH_SETUP   = 2'd0;
    localparam logic [1:0] PH_STROBE  = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    t_state     r_state, n_state;
    t_desc      r_desc, n_desc;
    logic [2:0] r_unit, n_unit;
    logic [1:0] r_phase, n_phase;
    logic       r_strobe, n_strobe;
    logic       r_rs, n_rs;
    logic       r_en, n_en;
    logic [7:0] r_bus, n_bus;
    logic [7:0] r_hold, n_hold;
    logic       r_last, n_last;
    logic       end_item;

    assign end_item = (r_state == S_UNIT) && (r_phase == PH_RELEASE) &&
                      (r_unit == last_unit(r_desc.is_init, i_cfg.bus_mode));
    assign o_pop    = i_valid && ((r_state == S_IDLE) || end_item);

    always_comb begin
        n_state  = r_state;
        n_desc   = r_desc;
        n_unit   = r_unit;
        n_phase  = r_phase;
        n_strobe = (r_state != S_IDLE);
        n_rs     = 1'b0;
        n_en     = 1'b0;
        n_bus    = 8'h00;
        n_hold   = 8'h00;
        n_last   = 1'b0;

        case (r_state)
            S_WAIT: begin
                n_hold = i_cfg.power_up_ms;
            end
            S_UNIT: begin
                n_rs   = r_desc.rs;
                n_en   = (r_phase == PH_STROBE);
                n_bus  = unit_bus(r_desc, i_cfg.bus_mode, r_unit);
                n_hold = (r_phase == PH_STROBE) ? i_cfg.pulse_ms : 8'h00;
                n_last = end_item;
            end
            default: ;
        endcase

        // advance
        case (r_state)
            S_WAIT: begin
                n_state = S_UNIT;
                n_unit  = 3'd0;
                n_phase = PH_SETUP;
            end
            S_UNIT: begin
                if (end_item) begin
                    n_state = S_IDLE;
                end else if (r_phase == PH_RELEASE) begin
                    n_unit  = r_unit + 3'd1;
                    n_phase = PH_SETUP;
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
            default: ;
        endcase

        if (o_pop) begin
            n_desc  = i_head;
            n_state = i_head.is_init ? S_WAIT : S_UNIT;
            n_unit  = 3'd0;
            n_phase = PH_SETUP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_desc   <= n_desc;
            r_unit   <= n_unit;
            r_phase  <= n_phase;
            r_rs     <= n_rs;
            r_en     <= n_en;
            r_bus    <= n_bus;
            r_hold   <= n_hold;
            r_last   <= n_last;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_reg_select = r_rs;
    assign o_read_write = 1'b0;
    assign o_enable     = r_en;
    assign o_bus        = r_bus;
    assign o_hold_ms    = r_hold;
    assign o_last       = r_last;

`ifndef SYNTHESIS
    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last flag without a pin state");
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> !o_strobe)
        else $error("pin state emitted from idle");
    a_pulse_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_enable) |-> (o_hold_ms == i_cfg.pulse_ms && !o_last))
        else $error("enable pulse with wrong hold or marked last");
    a_wait_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |=> (o_strobe && o_bus == 8'h00 && !o_enable))
        else $error("power-up wait state drove the bus");
`endif

endmodule

### rtl/char_lcd_bus_write_sequencer.sv
`timescale 1ns / 1ps
// A taken transaction waits in the queue until the pin sequencer is free; it is then
// popped into the sequencer's state, which drives the registered pin outputs.
// One pin state per cycle: setup, strobe and release per bus unit; init adds a wait first.
// A two-entry queue lets transactions follow with no gap; busy is high while it is full.
// Reset (synchronous, active low) empties the queue and loads 0, 2 and 40 into the registers.
// ----------------------------------------------------------------------------
// char_lcd_bus_write_sequencer
// Character LCD parallel-bus write sequencer with APB configuration.
// ----------------------------------------------------------------------------
module char_lcd_bus_write_sequencer
    import clbws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_byte_value,
    input  logic [5:0]  i_column,
    input  logic        i_row,
    output logic        o_strobe,
    output logic        o_reg_select,
    output logic        o_read_write,
    output logic        o_enable,
    output logic [7:0]  o_bus,
    output logic [7:0]  o_hold_ms,
    output logic        o_last
);

    t_cfg  cfg;
    t_desc push_desc;
    t_desc head_desc;
    logic  push;
    logic  pop;
    logic  full;
    logic  head_valid;

    assign busy = full;

    clbws_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    clbws_front u_front (
        .i_start      (start),
        .i_full       (full),
        .i_cmd        (i_cmd),
        .i_byte_value (i_byte_value),
        .i_column     (i_column),
        .i_row        (i_row),
        .o_push       (push),
        .o_desc       (push_desc)
    );

    clbws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head_desc)
    );

    clbws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (head_valid),
        .i_head       (head_desc),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_reg_select (o_reg_select),
        .o_read_write (o_read_write),
        .o_enable     (o_enable),
        .o_bus        (o_bus),
        .o_hold_ms    (o_hold_ms),
        .o_last       (o_last)
    );

endmodule

### tb/sv/char_lcd_bus_write_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_bus_write_sequencer_tb
// Self-checking bench for the character LCD bus write sequencer. A table of
// requests in both bus modes, some with hand-typed pin-state expectations, is
// followed by random requests under several register settings, the extremes
// among them. Every pin state is checked against an in-bench prediction of
// the sequence. Random gaps, none in burst phases; a watchdog ends stalls.
// ----------------------------------------------------------------------------
module char_lcd_bus_write_sequencer_tb;
    import clbws_pkg::*;

    localparam int DIR_ROWS      = 21;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 70;
    localparam int QUIET_LIMIT   = 1000;
    localparam int TAIL_CYCLES   = 10;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       en;
        logic [7:0] bus;
        logic [7:0] hold;
        logic       last;
    } lcd_pin_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] byte_value;
        logic [5:0] column;
        logic       row;
    } lcd_req_t;

    typedef struct packed {
        logic       mode;
        lcd_req_t   req;
        logic       typed;
        logic [4:0] n_pins;
        logic       rs;
        logic [7:0] bus1;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [7:0]  i_byte_value;
    logic [5:0]  i_column;
    logic        i_row;
    logic        o_strobe;
    logic        o_reg_select;
    logic        o_read_write;
    logic        o_enable;
    logic [7:0]  o_bus;
    logic [7:0]  o_hold_ms;
    logic        o_last;

    logic        cfg_mode;
    logic [7:0]  cfg_pulse;
    logic [7:0]  cfg_power_up;

    lcd_pin_t    req_pins[$];
    lcd_pin_t    pending_pins[$];
    int          mismatch_count;
    int          quiet_cycles;
    dir_row_t    dir_tab [0:DIR_ROWS-1];

    char_lcd_bus_write_sequencer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_byte_value (i_byte_value),
        .i_column     (i_column),
        .i_row        (i_row),
        .o_strobe     (o_strobe),
        .o_reg_select (o_reg_select),
        .o_read_write (o_read_write),
        .o_enable     (o_enable),
        .o_bus        (o_bus),
        .o_hold_ms    (o_hold_ms),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void add_pin(logic rs, logic en, logic [7:0] bus, logic [7:0] hold);
        lcd_pin_t p;
        p.rs   = rs;
        p.rw   = 1'b0;
        p.en   = en;
        p.bus  = bus;
        p.hold = hold;
        p.last = 1'b0;
        req_pins.push_back(p);
    endfunction

    function automatic void add_unit(logic rs, logic [7:0] bus);
        add_pin(rs, 1'b0, bus, 8'd0);
        add_pin(rs, 1'b1, bus, cfg_pulse);
        add_pin(rs, 1'b0, bus, 8'd0);
    endfunction

    function automatic void add_byte(logic rs, logic [7:0] b);
        if (cfg_mode) begin
            add_unit(rs, {b[7:4], 4'h0});
            add_unit(rs, {b[3:0], 4'h0});
        end else begin
            add_unit(rs, b);
        end
    endfunction

    function automatic void predict_pin_states(lcd_req_t r);
        logic [7:0] addr;
        lcd_pin_t   p;
        req_pins.delete();
        case (r.cmd)
            CMD_INIT: begin
                add_pin(1'b0, 1'b0, 8'h00, cfg_power_up);
                if (cfg_mode) begin
                    add_unit(1'b0, {FS_NIB_A, 4'h0});
                    add_unit(1'b0, {FS_NIB_A, 4'h0});
                    add_unit(1'b0, {FS_NIB_B, 4'h0});
                end else begin
                    add_byte(1'b0, FUNC_SET_8);
                end
                add_byte(1'b0, DISPLAY_ON);
                add_byte(1'b0, CLEAR_DISP);
            end
            CMD_WRCMD:  add_byte(1'b0, r.byte_value);
            CMD_WRDATA: add_byte(1'b1, r.byte_value);
            default: begin
                addr = r.row ? (ROW1_BASE + {2'b00, r.column}) : {2'b00, r.column};
                add_byte(1'b0, addr | DDRAM_FLAG);
            end
        endcase
        p = req_pins.pop_back();
        p.last = 1'b1;
        req_pins.push_back(p);
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BUS_MODE: cfg_mode     = val[0];
            REG_PULSE_MS: cfg_pulse    = val[7:0];
            default:      cfg_power_up = val[7:0];
        endcase
    endtask

    task automatic wait_bus_idle();
        start <= 1'b0;
        while (pending_pins.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic mode, input logic [7:0] pulse,
                                 input logic [7:0] power_up);
        wait_bus_idle();
        apb_write(REG_BUS_MODE, {31'd0, mode});
        apb_write(REG_PULSE_MS, {24'd0, pulse});
        apb_write(REG_POWER_UP_MS, {24'd0, power_up});
    endtask

    // Hold start until the transaction is taken, then queue its pin states
    task automatic issue_request(input lcd_req_t r, input int gap);
        start        <= 1'b1;
        i_cmd        <= r.cmd;
        i_byte_value <= r.byte_value;
        i_column     <= r.column;
        i_row        <= r.row;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_pin_states(r);
        foreach (req_pins[k]) pending_pins.push_back(req_pins[k]);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap(bit burst);
        int unsigned x;
        x = $urandom_range(0, 99);
        if (burst || x < 50) return 0;
        if (x < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic lcd_req_t pick_request();
        lcd_req_t r;
        r.cmd        = ($urandom_range(0, 9) == 0) ? CMD_INIT : 2'($urandom_range(1, 3));
        r.byte_value = 8'($urandom);
        r.column     = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 39));
        r.row        = 1'($urandom);
        return r;
    endfunction

    always @(posedge i_clk) begin
        lcd_pin_t got;
        lcd_pin_t want;
        if (i_rst_n && o_strobe) begin
            got = '{o_reg_select, o_read_write, o_enable, o_bus, o_hold_ms, o_last};
            if (pending_pins.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: unexpected pin state rs=%0b rw=%0b en=%0b bus=%02h hold=%0d last=%0b",
                             $realtime, got.rs, got.rw, got.en, got.bus, got.hold, got.last);
                mismatch_count++;
            end else begin
                want = pending_pins.pop_front();
                if (got !== want) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("%0t: pin state mismatch", $realtime);
                        $display("  exp rs=%0b rw=%0b en=%0b bus=%02h hold=%0d last=%0b",
                                 want.rs, want.rw, want.en, want.bus, want.hold, want.last);
                        $display("  got rs=%0b rw=%0b en=%0b bus=%02h hold=%0d last=%0b",
                                 got.rs, got.rw, got.en, got.bus, got.hold, got.last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        lcd_req_t   r;
        dir_row_t   d;
        logic [7:0] pulse;
        logic [7:0] power_up;

        mismatch_count = 0;
        quiet_cycles   = 0;
        cfg_mode       = 1'b0;
        cfg_pulse      = RST_PULSE_MS;
        cfg_power_up   = RST_POWER_UP_MS;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        start          <= 1'b0;
        i_cmd          <= CMD_INIT;
        i_byte_value   <= '0;
        i_column       <= '0;
        i_row          <= 1'b0;

        dir_tab = '{
            '{1'b0, '{CMD_INIT,   8'h00, 6'd0,  1'b0}, 1'b1, 5'd10, 1'b0, 8'h38},
            '{1'b0, '{CMD_WRCMD,  8'h00, 6'd0,  1'b0}, 1'b1, 5'd3,  1'b0, 8'h00},
            '{1'b0, '{CMD_WRCMD,  8'hFF, 6'd63, 1'b1}, 1'b1, 5'd3,  1'b0, 8'hFF},
            '{1'b0, '{CMD_WRDATA, 8'h00, 6'd63, 1'b1}, 1'b1, 5'd3,  1'b1, 8'h00},
            '{1'b0, '{CMD_WRDATA, 8'hFF, 6'd0,  1'b0}, 1'b1, 5'd3,  1'b1, 8'hFF},
            '{1'b0, '{CMD_WRDATA, 8'hA5, 6'd21, 1'b0}, 1'b1, 5'd3,  1'b1, 8'hA5},
            '{1'b0, '{CMD_CURSOR, 8'hFF, 6'd0,  1'b0}, 1'b1, 5'd3,  1'b0, 8'h80},
            '{1'b0, '{CMD_CURSOR, 8'h00, 6'd39, 1'b0}, 1'b1, 5'd3,  1'b0, 8'hA7},
            '{1'b0, '{CMD_CURSOR, 8'h00, 6'd0,  1'b1}, 1'b1, 5'd3,  1'b0, 8'hC0},
            '{1'b0, '{CMD_CURSOR, 8'h00, 6'd39, 1'b1}, 1'b1, 5'd3,  1'b0, 8'hE7},
            '{1'b0, '{CMD_CURSOR, 8'h5A, 6'd63, 1'b1}, 1'b1, 5'd3,  1'b0, 8'hFF},
            '{1'b0, '{CMD_CURSOR, 8'h00, 6'd63, 1'b0}, 1'b1, 5'd3,  1'b0, 8'hBF},
            '{1'b1, '{CMD_INIT,   8'hFF, 6'd63, 1'b1}, 1'b1, 5'd22, 1'b0, 8'h20},
            '{1'b1, '{CMD_WRCMD,  8'h3C, 6'd0,  1'b0}, 1'b1, 5'd6,  1'b0, 8'h30},
            '{1'b1, '{CMD_WRDATA, 8'hFF, 6'd0,  1'b0}, 1'b1, 5'd6,  1'b1, 8'hF0},
            '{1'b1, '{CMD_WRDATA, 8'h0F, 6'd0,  1'b0}, 1'b1, 5'd6,  1'b1, 8'h00},
            '{1'b1, '{CMD_WRDATA, 8'h5A, 6'd42, 1'b1}, 1'b1, 5'd6,  1'b1, 8'h50},
            '{1'b1, '{CMD_CURSOR, 8'h00, 6'd39, 1'b1}, 1'b1, 5'd6,  1'b0, 8'hE0},
            '{1'b1, '{CMD_CURSOR, 8'h00, 6'd7,  1'b0}, 1'b1, 5'd6,  1'b0, 8'h80},
            '{1'b1, '{CMD_WRCMD,  8'hC3, 6'd5,  1'b1}, 1'b0, 5'd0,  1'b0, 8'h00},
            '{1'b1, '{CMD_INIT,   8'h00, 6'd0,  1'b0}, 1'b0, 5'd0,  1'b0, 8'h00}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            d = dir_tab[i];
            if (d.mode != cfg_mode) begin
                wait_bus_idle();
                apb_write(REG_BUS_MODE, {31'd0, d.mode});
            end
            issue_request(d.req, pick_gap(1'b0));
            if (d.typed && (req_pins.size() != int'(d.n_pins) || req_pins[0].rs !== d.rs
                            || req_pins[1].bus !== d.bus1)) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("table row %0d: exp %0d pins rs=%0b bus=%02h, predicted %0d",
                             i, d.n_pins, d.rs, d.bus1, req_pins.size());
                mismatch_count++;
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            pulse    = 8'($urandom);
            power_up = 8'($urandom);
            case (ph)
                0:       load_settings(1'b1, 8'd0,   8'd0);
                1:       load_settings(1'b0, 8'd255, 8'd255);
                2:       load_settings(1'b1, pulse,  power_up);
                3:       load_settings(1'b0, pulse,  power_up);
                4:       load_settings(1'b1, 8'd255, 8'd255);
                default: load_settings(1'b0, 8'd0,   8'd0);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = pick_request();
                issue_request(r, pick_gap(ph == 2 || ph == 5));
            end
        end

        wait_bus_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_pins.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
rtl/clbws_pkg.sv
rtl/clbws_regs.sv
rtl/clbws_front.sv
rtl/clbws_queue.sv
rtl/clbws_back.sv
rtl/char_lcd_bus_write_sequencer.sv
tb/sv/char_lcd_bus_write_sequencer_tb.sv
